// ===== rtl/core/lumi_pkg.sv =====
// Shared types, constants and helpers for the LU matrix inverse block.
package lumi_pkg;

  localparam int ORDER     = 4;
  localparam int FRAC_BITS = 16;

  localparam int IW = $clog2(ORDER);
  localparam int CW = $clog2(ORDER + 1);
  localparam int VW = 48;
  localparam int AW = 3 + 2 * IW;

  localparam logic signed [VW-1:0] VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VW-1:0] VONE = VW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    RG_IN,
    RG_L,
    RG_U,
    RG_XU,
    RG_YL
  } region_t;

  typedef enum logic [1:0] {
    INIT_MEM,
    INIT_ZERO,
    INIT_ONE
  } init_t;

  typedef enum logic [1:0] {
    WR_IN,
    WR_ACC,
    WR_ACC_NEG,
    WR_QUO
  } wsel_t;

  typedef enum logic [2:0] {
    FIN_STORE,
    FIN_STORE_NEG,
    FIN_DIV,
    FIN_DIV_NEG,
    FIN_EMIT
  } fin_t;

  typedef enum logic [2:0] {
    PH_FU,
    PH_FL,
    PH_XD,
    PH_XU,
    PH_YD,
    PH_YL,
    PH_PR
  } ph_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_INIT_W,
    ST_MRD,
    ST_MWAIT,
    ST_MBUSY,
    ST_FIN,
    ST_DRD,
    ST_DBUSY,
    ST_STORE,
    ST_EMIT,
    ST_SING
  } st_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          acc_load;
    init_t         init_sel;
    logic          mac_start;
    logic          mac_sub;
    logic          div_start;
    logic          div_neg;
    logic          wr_en;
    wsel_t         wr_sel;
    logic [AW-1:0] wr_addr;
    logic          emit;
    logic          emit_sing;
    logic          emit_last;
    logic [1:0]    row;
    logic [1:0]    col;
    logic          clear_sat;
  } cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic div_busy;
    logic pivot_small;
    logic out_full;
  } sts_t;

  function automatic logic [VW-1:0] vmag(logic signed [VW-1:0] v);
    vmag = v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic [AW-1:0] mk_addr(region_t rg, logic [IW-1:0] r, logic [IW-1:0] c);
    mk_addr = {rg, r, c};
  endfunction

endpackage

// ===== rtl/core/lumi_div.sv =====
// Restoring divider: (|num| << FRAC_BITS) / |den|, one quotient bit per cycle, saturated.
module lumi_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [lumi_pkg::VW-1:0]     num,
  input  logic signed [lumi_pkg::VW-1:0]     den,
  output logic                               busy,
  output logic signed [lumi_pkg::VW-1:0]     quo,
  output logic                               sat
);

  localparam int VW  = lumi_pkg::VW;
  localparam int DW  = VW + lumi_pkg::FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);

  logic [DW-1:0]  dvd;
  logic [DW-1:0]  q;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  d;
  logic [DCW-1:0] cnt;
  logic           neg;

  logic [VW:0]    sh;
  logic           fits;
  logic           ovf;
  logic [VW-1:0]  qm;

  always_comb begin
    sh   = {rem, dvd[DW-1]};
    fits = sh >= {1'b0, d};
    ovf  = |q[DW-1:VW-1];
    qm   = ovf ? VW'(lumi_pkg::VMAX) : {1'b0, q[VW-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      dvd  <= {lumi_pkg::vmag(num), {lumi_pkg::FRAC_BITS{1'b0}}};
      d    <= lumi_pkg::vmag(den);
      rem  <= '0;
      q    <= '0;
      cnt  <= DCW'(DW);
      neg  <= num[VW-1] ^ den[VW-1];
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= fits ? VW'(sh - {1'b0, d}) : sh[VW-1:0];
        q   <= {q[DW-2:0], fits};
        dvd <= dvd << 1;
        cnt <= cnt - DCW'(1);
      end else begin
        // all quotient bits in: clip and apply sign
        quo  <= neg ? -$signed(qm) : $signed(qm);
        sat  <= ovf;
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/lumi_dp.sv =====
// Datapath: work memory, multiply-accumulate unit, divider, threshold and result register.
module lumi_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  lumi_pkg::cmd_t        cmd,
  output lumi_pkg::sts_t        sts,
  input  logic signed [31:0]    element_value,
  input  logic                  cfg_write_en,
  input  logic [30:0]           cfg_write_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [31:0]    inverse_value,
  output logic [1:0]            row_index,
  output logic [1:0]            col_index,
  output logic                  last_result,
  output logic                  singular_flag,
  output logic                  saturated_flag
);

  localparam int VW = lumi_pkg::VW;
  localparam int AW = lumi_pkg::AW;
  localparam int HW = VW / 2;
  localparam int PW = 2 * VW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [PW-1:0] HALF = PW'(1) << (lumi_pkg::FRAC_BITS - 1);
  localparam logic signed [VW:0] SMAX = {1'b0, lumi_pkg::VMAX};
  localparam logic signed [VW:0] SMIN = -SMAX;
  localparam logic signed [VW-1:0] O_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [VW-1:0] O_MIN = -48'sh0000_8000_0000;

  logic signed [VW-1:0] mem [0:MEM_DEPTH-1];
  logic signed [VW-1:0] rd_a;
  logic signed [VW-1:0] rd_b;
  logic signed [VW-1:0] wdata;

  logic signed [VW-1:0] acc;
  logic                 sat_any;
  logic [30:0]          thr;

  logic [VW-1:0]        ma;
  logic [VW-1:0]        mb;
  logic                 mneg;
  logic                 msub;
  logic [2:0]           mstep;
  logic                 mac_busy;
  logic [2*HW-1:0]      pp;
  logic [1:0]           psh;
  logic [PW-1:0]        prod;
  logic signed [VW-1:0] term;
  logic                 tsat;

  logic [HW-1:0]        ha;
  logic [HW-1:0]        hb;
  logic [PW-1:0]        pp_ext;
  logic                 povf;
  logic [VW-1:0]        pm;
  logic signed [VW:0]   sum;

  logic                 div_busy;
  logic signed [VW-1:0] quo;
  logic                 div_sat;

  logic                 clip;
  logic signed [31:0]   clipped;

  always_comb begin
    case (cmd.wr_sel)
      lumi_pkg::WR_IN:      wdata = VW'(element_value);
      lumi_pkg::WR_ACC:     wdata = acc;
      lumi_pkg::WR_ACC_NEG: wdata = -acc;
      lumi_pkg::WR_QUO:     wdata = quo;
      default:              wdata = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[cmd.addr_a];
      rd_b <= mem[cmd.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 31'd1;
    end else if (cfg_write_en) begin
      thr <= cfg_write_data;
    end
  end

  // multiply-accumulate: four 24x24 partials, round, clip, saturating add
  always_comb begin
    ha = mstep[1] ? ma[VW-1:HW] : ma[HW-1:0];
    hb = mstep[0] ? mb[VW-1:HW] : mb[HW-1:0];
    case (psh)
      2'd0:    pp_ext = PW'(pp);
      2'd1:    pp_ext = PW'(pp) << HW;
      default: pp_ext = PW'(pp) << (2 * HW);
    endcase
    povf = |prod[PW-1:VW-1];
    pm   = povf ? VW'(lumi_pkg::VMAX) : {1'b0, prod[VW-2:0]};
    sum  = {term[VW-1], term} + {acc[VW-1], acc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_busy <= 1'b0;
    end else if (cmd.mac_start) begin
      mac_busy <= 1'b1;
      ma       <= lumi_pkg::vmag(rd_a);
      mb       <= lumi_pkg::vmag(rd_b);
      mneg     <= rd_a[VW-1] ^ rd_b[VW-1];
      msub     <= cmd.mac_sub;
      mstep    <= '0;
      prod     <= '0;
    end else if (mac_busy) begin
      mstep <= mstep + 3'd1;
      case (mstep)
        3'd0, 3'd1, 3'd2, 3'd3: begin
          pp  <= ha * hb;
          psh <= {1'b0, mstep[1]} + {1'b0, mstep[0]};
          if (mstep != 3'd0) begin
            prod <= prod + pp_ext;
          end
        end
        3'd4: prod <= prod + pp_ext;
        3'd5: prod <= (prod + HALF) >> lumi_pkg::FRAC_BITS;
        3'd6: begin
          tsat <= povf;
          term <= (mneg ^ msub) ? -$signed(pm) : $signed(pm);
        end
        default: mac_busy <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      case (cmd.init_sel)
        lumi_pkg::INIT_MEM:  acc <= rd_a;
        lumi_pkg::INIT_ONE:  acc <= lumi_pkg::VONE;
        default:             acc <= '0;
      endcase
    end else if (mac_busy && mstep == 3'd7) begin
      if (sum > SMAX) begin
        acc <= lumi_pkg::VMAX;
      end else if (sum < SMIN) begin
        acc <= -lumi_pkg::VMAX;
      end else begin
        acc <= sum[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_sat) begin
      sat_any <= 1'b0;
    end else if (mac_busy && mstep == 3'd7) begin
      sat_any <= sat_any | tsat | (sum > SMAX) | (sum < SMIN);
    end else if (cmd.wr_en && cmd.wr_sel == lumi_pkg::WR_QUO) begin
      sat_any <= sat_any | div_sat;
    end
  end

  lumi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_neg ? -acc : acc),
    .den   (rd_b),
    .busy  (div_busy),
    .quo   (quo),
    .sat   (div_sat)
  );

  always_comb begin
    clip = 1'b1;
    if (acc > O_MAX) begin
      clipped = 32'sh7FFF_FFFF;
    end else if (acc < O_MIN) begin
      clipped = 32'sh8000_0000;
    end else begin
      clipped = acc[31:0];
      clip    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid      <= 1'b1;
      inverse_value  <= cmd.emit_sing ? 32'sd0 : clipped;
      row_index      <= cmd.row;
      col_index      <= cmd.col;
      last_result    <= cmd.emit_last;
      singular_flag  <= cmd.emit_sing;
      saturated_flag <= cmd.emit_sing ? 1'b0 : (clip | sat_any);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.mac_busy    = mac_busy;
    sts.div_busy    = div_busy;
    sts.pivot_small = (acc == '0) || (lumi_pkg::vmag(acc) < VW'(thr));
    sts.out_full    = out_valid;
  end

endmodule

// ===== rtl/core/lumi_ctrl.sv =====
// Sequencer: load, factor, triangular inversions and product, as jobs over the datapath.
module lumi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  lumi_pkg::sts_t sts,
  output lumi_pkg::cmd_t cmd
);

  localparam int IW = lumi_pkg::IW;
  localparam int CW = lumi_pkg::CW;
  localparam logic [IW-1:0] N1 = IW'(lumi_pkg::ORDER - 1);

  lumi_pkg::st_t st, st_next;
  lumi_pkg::ph_t ph, ph_next;
  logic [IW-1:0] i, i_next;
  logic [IW-1:0] j, j_next;
  logic [CW-1:0] k, k_next;

  logic [IW-1:0]        kx;
  logic [CW-1:0]        kstart;
  logic [CW-1:0]        kend;
  lumi_pkg::init_t      init_sel;
  lumi_pkg::fin_t       fin;
  logic                 sub;
  logic [lumi_pkg::AW-1:0] init_addr, a_addr, b_addr, piv_addr, st_addr;

  lumi_pkg::ph_t aph;
  logic [IW-1:0] ai;
  logic [IW-1:0] aj;
  logic          adone;
  logic          slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= lumi_pkg::ST_LOAD;
      ph <= lumi_pkg::PH_FU;
      i  <= '0;
      j  <= '0;
      k  <= '0;
    end else begin
      st <= st_next;
      ph <= ph_next;
      i  <= i_next;
      j  <= j_next;
      k  <= k_next;
    end
  end

  // per-job decode: loop range, operands, where the result goes
  always_comb begin
    kx        = k[IW-1:0];
    kstart    = '0;
    kend      = '0;
    init_sel  = lumi_pkg::INIT_ZERO;
    fin       = lumi_pkg::FIN_STORE;
    sub       = 1'b0;
    init_addr = lumi_pkg::mk_addr(lumi_pkg::RG_IN, i, j);
    a_addr    = lumi_pkg::mk_addr(lumi_pkg::RG_L, i, kx);
    b_addr    = lumi_pkg::mk_addr(lumi_pkg::RG_U, kx, j);
    piv_addr  = lumi_pkg::mk_addr(lumi_pkg::RG_U, i, i);
    st_addr   = lumi_pkg::mk_addr(lumi_pkg::RG_U, i, j);
    case (ph)
      lumi_pkg::PH_FU: begin
        kend     = CW'(i);
        init_sel = lumi_pkg::INIT_MEM;
        sub      = 1'b1;
      end
      lumi_pkg::PH_FL: begin
        kend      = CW'(i);
        init_sel  = lumi_pkg::INIT_MEM;
        sub       = 1'b1;
        fin       = lumi_pkg::FIN_DIV;
        init_addr = lumi_pkg::mk_addr(lumi_pkg::RG_IN, j, i);
        a_addr    = lumi_pkg::mk_addr(lumi_pkg::RG_L, j, kx);
        b_addr    = lumi_pkg::mk_addr(lumi_pkg::RG_U, kx, i);
        st_addr   = lumi_pkg::mk_addr(lumi_pkg::RG_L, j, i);
      end
      lumi_pkg::PH_XD: begin
        init_sel = lumi_pkg::INIT_ONE;
        fin      = lumi_pkg::FIN_DIV;
        piv_addr = lumi_pkg::mk_addr(lumi_pkg::RG_U, j, j);
        st_addr  = lumi_pkg::mk_addr(lumi_pkg::RG_XU, j, j);
      end
      lumi_pkg::PH_XU: begin
        kstart  = CW'(i) + CW'(1);
        kend    = CW'(j) + CW'(1);
        fin     = lumi_pkg::FIN_DIV_NEG;
        a_addr  = lumi_pkg::mk_addr(lumi_pkg::RG_U, i, kx);
        b_addr  = lumi_pkg::mk_addr(lumi_pkg::RG_XU, kx, j);
        st_addr = lumi_pkg::mk_addr(lumi_pkg::RG_XU, i, j);
      end
      lumi_pkg::PH_YD: begin
        init_sel = lumi_pkg::INIT_ONE;
        st_addr  = lumi_pkg::mk_addr(lumi_pkg::RG_YL, j, j);
      end
      lumi_pkg::PH_YL: begin
        kstart  = CW'(j);
        kend    = CW'(i);
        fin     = lumi_pkg::FIN_STORE_NEG;
        b_addr  = lumi_pkg::mk_addr(lumi_pkg::RG_YL, kx, j);
        st_addr = lumi_pkg::mk_addr(lumi_pkg::RG_YL, i, j);
      end
      lumi_pkg::PH_PR: begin
        // terms below the diagonals of either factor are zero: skip them
        kstart = (i > j) ? CW'(i) : CW'(j);
        kend   = CW'(lumi_pkg::ORDER);
        fin    = lumi_pkg::FIN_EMIT;
        a_addr = lumi_pkg::mk_addr(lumi_pkg::RG_XU, i, kx);
        b_addr = lumi_pkg::mk_addr(lumi_pkg::RG_YL, kx, j);
      end
      default: ;
    endcase
  end

  // next job after the current one
  always_comb begin
    aph   = ph;
    ai    = i;
    aj    = j;
    adone = 1'b0;
    case (ph)
      lumi_pkg::PH_FU: begin
        if (j == N1) begin
          if (i == N1) begin
            aph = lumi_pkg::PH_XD;
            aj  = '0;
          end else begin
            aph = lumi_pkg::PH_FL;
            aj  = i + IW'(1);
          end
        end else begin
          aj = j + IW'(1);
        end
      end
      lumi_pkg::PH_FL: begin
        if (j == N1) begin
          aph = lumi_pkg::PH_FU;
          ai  = i + IW'(1);
          aj  = i + IW'(1);
        end else begin
          aj = j + IW'(1);
        end
      end
      lumi_pkg::PH_XD: begin
        if (j == '0) begin
          aj = j + IW'(1);
        end else begin
          aph = lumi_pkg::PH_XU;
          ai  = j - IW'(1);
        end
      end
      lumi_pkg::PH_XU: begin
        if (i == '0) begin
          if (j == N1) begin
            aph = lumi_pkg::PH_YD;
            aj  = '0;
          end else begin
            aph = lumi_pkg::PH_XD;
            aj  = j + IW'(1);
          end
        end else begin
          ai = i - IW'(1);
        end
      end
      lumi_pkg::PH_YD: begin
        if (j == N1) begin
          aph = lumi_pkg::PH_PR;
          ai  = '0;
          aj  = '0;
        end else begin
          aph = lumi_pkg::PH_YL;
          ai  = j + IW'(1);
        end
      end
      lumi_pkg::PH_YL: begin
        if (i == N1) begin
          aph = lumi_pkg::PH_YD;
          aj  = j + IW'(1);
        end else begin
          ai = i + IW'(1);
        end
      end
      lumi_pkg::PH_PR: begin
        if (j == N1) begin
          aj = '0;
          if (i == N1) begin
            adone = 1'b1;
            ai    = '0;
          end else begin
            ai = i + IW'(1);
          end
        end else begin
          aj = j + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_next   = st;
    ph_next   = ph;
    i_next    = i;
    j_next    = j;
    k_next    = k;
    cmd       = '0;
    in_ready  = 1'b0;
    slot_free = !sts.out_full || out_ready;
    case (st)
      lumi_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = lumi_pkg::WR_IN;
          cmd.wr_addr = lumi_pkg::mk_addr(lumi_pkg::RG_IN, i, j);
          if (j == N1) begin
            j_next = '0;
            if (i == N1) begin
              i_next        = '0;
              ph_next       = lumi_pkg::PH_FU;
              cmd.clear_sat = 1'b1;
              st_next       = lumi_pkg::ST_INIT;
            end else begin
              i_next = i + IW'(1);
            end
          end else begin
            j_next = j + IW'(1);
          end
        end
      end
      lumi_pkg::ST_INIT: begin
        cmd.rd_en  = 1'b1;
        cmd.addr_a = init_addr;
        k_next     = kstart;
        st_next    = lumi_pkg::ST_INIT_W;
      end
      lumi_pkg::ST_INIT_W: begin
        cmd.acc_load = 1'b1;
        cmd.init_sel = init_sel;
        st_next      = (k == kend) ? lumi_pkg::ST_FIN : lumi_pkg::ST_MRD;
      end
      lumi_pkg::ST_MRD: begin
        cmd.rd_en  = 1'b1;
        cmd.addr_a = a_addr;
        cmd.addr_b = b_addr;
        st_next    = lumi_pkg::ST_MWAIT;
      end
      lumi_pkg::ST_MWAIT: begin
        cmd.mac_start = 1'b1;
        cmd.mac_sub   = sub;
        st_next       = lumi_pkg::ST_MBUSY;
      end
      lumi_pkg::ST_MBUSY: begin
        if (!sts.mac_busy) begin
          k_next  = k + CW'(1);
          st_next = (k + CW'(1) == kend) ? lumi_pkg::ST_FIN : lumi_pkg::ST_MRD;
        end
      end
      lumi_pkg::ST_FIN: begin
        case (fin)
          lumi_pkg::FIN_DIV, lumi_pkg::FIN_DIV_NEG: begin
            cmd.rd_en  = 1'b1;
            cmd.addr_b = piv_addr;
            st_next    = lumi_pkg::ST_DRD;
          end
          lumi_pkg::FIN_EMIT: st_next = lumi_pkg::ST_EMIT;
          default:            st_next = lumi_pkg::ST_STORE;
        endcase
      end
      lumi_pkg::ST_DRD: begin
        cmd.div_start = 1'b1;
        cmd.div_neg   = (fin == lumi_pkg::FIN_DIV_NEG);
        st_next       = lumi_pkg::ST_DBUSY;
      end
      lumi_pkg::ST_DBUSY: begin
        if (!sts.div_busy) begin
          st_next = lumi_pkg::ST_STORE;
        end
      end
      lumi_pkg::ST_STORE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = st_addr;
        case (fin)
          lumi_pkg::FIN_STORE:     cmd.wr_sel = lumi_pkg::WR_ACC;
          lumi_pkg::FIN_STORE_NEG: cmd.wr_sel = lumi_pkg::WR_ACC_NEG;
          default:                 cmd.wr_sel = lumi_pkg::WR_QUO;
        endcase
        if (ph == lumi_pkg::PH_FU && i == j && sts.pivot_small) begin
          st_next = lumi_pkg::ST_SING;
        end else begin
          ph_next = aph;
          i_next  = ai;
          j_next  = aj;
          st_next = lumi_pkg::ST_INIT;
        end
      end
      lumi_pkg::ST_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = adone;
          cmd.row       = 2'(i);
          cmd.col       = 2'(j);
          ph_next       = aph;
          i_next        = ai;
          j_next        = aj;
          st_next       = adone ? lumi_pkg::ST_LOAD : lumi_pkg::ST_INIT;
        end
      end
      lumi_pkg::ST_SING: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sing = 1'b1;
          cmd.emit_last = 1'b1;
          i_next        = '0;
          j_next        = '0;
          st_next       = lumi_pkg::ST_LOAD;
        end
      end
      default: st_next = lumi_pkg::ST_LOAD;
    endcase
  end

endmodule

// ===== rtl/core/lu_matrix_inverse.sv =====
// Top level: fixed-point 4x4 matrix inverse through Doolittle LU factorization.
//
// Input channel (in_valid/in_ready, element_value): the matrix, one signed
// Q16.16 element per transfer in row-major order. in_ready is high only
// while the block is collecting a matrix; the transfer that completes the
// matrix starts the computation.
// Output channel (out_valid/out_ready): the 16 inverse elements in row-major
// order with their row and column, the last marked by last_result. A
// singular matrix (a pivot of magnitude below det_threshold, or zero) gives
// one result with singular_flag set and value zero.
// The computation is dominated by the serial divider (64 quotient bits
// per quotient, 16 quotients per matrix) and the shared multiply-accumulate
// unit (64 terms per matrix). A new matrix is taken only after the last
// result of the previous one has been issued. A held output stalls the
// sequencer at the next result, nothing is lost; the next matrix may be
// loaded while the last result waits.
// cfg_write_en/cfg_write_data set det_threshold; write only while idle.
// Reset (rst, synchronous) empties the pipeline, restarts loading at
// element zero and sets det_threshold to 1.
module lu_matrix_inverse (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] inverse_value,
  output logic [1:0]         row_index,
  output logic [1:0]         col_index,
  output logic               last_result,
  output logic               singular_flag,
  output logic               saturated_flag,
  input  logic               cfg_write_en,
  input  logic [30:0]        cfg_write_data
);

  lumi_pkg::cmd_t cmd;
  lumi_pkg::sts_t sts;

  lumi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lumi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .element_value  (element_value),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .inverse_value  (inverse_value),
    .row_index      (row_index),
    .col_index      (col_index),
    .last_result    (last_result),
    .singular_flag  (singular_flag),
    .saturated_flag (saturated_flag)
  );

`ifndef SYNTHESIS
  a_sing_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular_flag |-> last_result && inverse_value == 32'sd0 && !saturated_flag)
    else $error("singular result malformed");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.mac_busy && !sts.div_busy)
    else $error("input taken while arithmetic units busy");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
